/* rtl/blt_pkg.sv */
// Package for the byte-range lock table: word types, state codes and constants.
// Used by every module of the block except the table memory; has no dependencies of its own.

package blt_pkg;

  localparam int TABLE_ENTRIES_DEF  = 64;
  localparam int OBJECT_ID_BITS_DEF = 32;
  localparam int OWNER_ID_BITS_DEF  = 16;

  // Width of the entry fields that do not follow a parameter:
  // valid, start, length, write flag and the 32-bit range end.
  localparam int ENTRY_FIXED_BITS = 1 + 31 + 31 + 1 + 32;

  // Range end used when the length is zero.
  localparam logic [31:0] RANGE_TOP = 32'h7fff_ffff;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_SET   = 1'b1;

  localparam logic [1:0] KIND_READ       = 2'd0;
  localparam logic [1:0] KIND_WRITE      = 2'd1;
  localparam int         KIND_UNLOCK_BIT = 1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_BLOCK = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] FOUND_READ  = 2'd0;
  localparam logic [1:0] FOUND_WRITE = 2'd1;
  localparam logic [1:0] FOUND_NONE  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] object_id;
    logic [1:0]  lock_kind;
    logic [30:0] range_start;
    logic [30:0] range_length;
    logic [15:0] owner_id;
  } blt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  found_kind;
    logic [30:0] found_start;
    logic [30:0] found_length;
    logic [15:0] found_owner;
  } blt_rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } blt_state_t;

endpackage

/* rtl/blt_table_mem.sv */
// Lock table storage: one write port, one read port, registered read data.
// No package dependencies; widths come from the parent.

module blt_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 144,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/blt_out_reg.sv */
// Output register of the lock table: holds one result word until taken.
// Depends on blt_pkg for the result word type.

module blt_out_reg
  import blt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  blt_rsp_t load_word,
  output logic     slot_free,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output blt_rsp_t rsp
);

  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= load_word;
    end
  end

endmodule

/* rtl/blt_scan_ctrl.sv */
// Scan sequencer of the lock table: clears the table after reset, then walks
// every entry per request and writes back. Depends on blt_pkg.

module blt_scan_ctrl
  import blt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int OBJECT_ID_BITS = OBJECT_ID_BITS_DEF,
  parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF,
  localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int EntryW = ENTRY_FIXED_BITS + OBJECT_ID_BITS + OWNER_ID_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  blt_req_t          req,
  input  logic              slot_free,
  output logic              res_load,
  output blt_rsp_t          res_word,
  output logic              mem_we,
  output logic [AddrW-1:0]  mem_waddr,
  output logic [EntryW-1:0] mem_wdata,
  output logic [AddrW-1:0]  mem_raddr,
  input  logic [EntryW-1:0] mem_rdata
);

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(TABLE_ENTRIES - 1);
  localparam logic [CntW-1:0] EndIdx = CntW'(TABLE_ENTRIES);

  typedef struct packed {
    logic                      valid;
    logic [OBJECT_ID_BITS-1:0] obj;
    logic [OWNER_ID_BITS-1:0]  owner;
    logic [30:0]               start;
    logic [30:0]               len;
    logic                      is_write;
    logic [31:0]               end_pos;
  } entry_t;

  blt_state_t state, state_next;
  logic [CntW-1:0] idx;
  logic chk_valid;
  logic [AddrW-1:0] chk_idx;

  logic                      cur_op;
  logic [OBJECT_ID_BITS-1:0] cur_obj;
  logic [OWNER_ID_BITS-1:0]  cur_owner;
  logic [30:0]               cur_start;
  logic [30:0]               cur_len;
  logic                      cur_write;
  logic                      cur_unlock;
  logic [31:0]               cur_end;

  logic found;
  entry_t found_entry;
  logic conflict;
  logic have_own;
  logic [AddrW-1:0] own_idx;
  logic have_free;
  logic [AddrW-1:0] free_idx;

  entry_t rd_entry;
  entry_t new_entry;
  logic same_obj;
  logic same_owner;
  logic overlap;
  logic any_write;
  logic blocks;
  logic [31:0] req_end;

  assign rd_entry = entry_t'(mem_rdata);
  assign mem_raddr = idx[AddrW-1:0];

  // The entry end is kept in the table so that the scan only compares.
  assign req_end = (req.range_length != 31'd0)
                 ? ({1'b0, req.range_start} + {1'b0, req.range_length})
                 : RANGE_TOP;

  assign same_obj = rd_entry.valid && (rd_entry.obj == cur_obj);
  assign same_owner = (rd_entry.owner == cur_owner);
  assign overlap = !((rd_entry.end_pos <= {1'b0, cur_start}) ||
                     (cur_end <= {1'b0, rd_entry.start}));
  assign any_write = rd_entry.is_write || cur_write;
  assign blocks = same_obj && overlap && any_write;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.obj = cur_obj;
    new_entry.owner = cur_owner;
    new_entry.start = cur_start;
    new_entry.len = cur_len;
    new_entry.is_write = cur_write;
    new_entry.end_pos = cur_end;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (idx == LastIdx) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (idx == EndIdx) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    entry_t cleared;
    cleared = rd_entry;
    cleared.valid = 1'b0;
    req_stall = 1'b1;
    res_load = 1'b0;
    mem_we = 1'b0;
    mem_waddr = chk_idx;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = idx[AddrW-1:0];
      end
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_SCAN: begin
        if (chk_valid && cur_op == OP_SET && cur_unlock && same_obj && same_owner) begin
          mem_we = 1'b1;
          mem_wdata = EntryW'(cleared);
        end
      end
      S_FINISH: begin
        res_load = slot_free;
        if (slot_free && cur_op == OP_SET && !cur_unlock && !conflict &&
            (have_own || have_free)) begin
          mem_we = 1'b1;
          mem_waddr = have_own ? own_idx : free_idx;
          mem_wdata = EntryW'(new_entry);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_word.status = STATUS_DONE;
    res_word.found_kind = FOUND_NONE;
    res_word.found_start = '0;
    res_word.found_length = '0;
    res_word.found_owner = '0;
    if (cur_op == OP_QUERY) begin
      if (found) begin
        res_word.found_kind = found_entry.is_write ? FOUND_WRITE : FOUND_READ;
        res_word.found_start = found_entry.start;
        res_word.found_length = found_entry.len;
        res_word.found_owner = 16'(found_entry.owner);
      end
    end else if (!cur_unlock) begin
      if (conflict) begin
        res_word.status = STATUS_BLOCK;
      end else if (!have_own && !have_free) begin
        res_word.status = STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk_valid <= (state == S_SCAN) && (idx != EndIdx);
      case (state)
        S_CLEAR: idx <= idx + 1'b1;
        S_SCAN:  if (idx != EndIdx) idx <= idx + 1'b1;
        default: idx <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx[AddrW-1:0];
    if (state == S_IDLE && req_valid) begin
      cur_op <= req.operation;
      cur_obj <= OBJECT_ID_BITS'(req.object_id);
      cur_owner <= OWNER_ID_BITS'(req.owner_id);
      cur_start <= req.range_start;
      cur_len <= req.range_length;
      cur_write <= (req.lock_kind == KIND_WRITE);
      cur_unlock <= req.lock_kind[KIND_UNLOCK_BIT];
      cur_end <= req_end;
      found <= 1'b0;
      conflict <= 1'b0;
      have_own <= 1'b0;
      have_free <= 1'b0;
    end else if (state == S_SCAN && chk_valid) begin
      if (blocks && !found) begin
        found <= 1'b1;
        found_entry <= rd_entry;
      end
      if (blocks && !same_owner) begin
        conflict <= 1'b1;
      end
      if (same_obj && same_owner && !have_own) begin
        have_own <= 1'b1;
        own_idx <= chk_idx;
      end
      if (!rd_entry.valid && !have_free) begin
        have_free <= 1'b1;
        free_idx <= chk_idx;
      end
    end
  end

endmodule

/* rtl/byte_range_lock_table.sv */
// Byte-range lock table, top level. Instantiates the scan sequencer, the table
// memory and the output register; depends on blt_pkg.
//
// Usage: requests arrive as one word on the req channel (req_valid, req_stall,
// req) and each request gives exactly one result word on the rsp channel
// (rsp_valid, rsp_stall, rsp). A word moves at a clock edge where valid is
// high and stall is low. Operation 0 queries for a blocking lock, operation 1
// sets a read or write lock or releases all locks of an owner on an object.
//
// Every request walks the whole table through the memory read port, one entry
// per cycle; its result word is then loaded into the output register as soon as
// that register is free, and the receiver can take it at the next edge. The
// conflict check, the search for the owner's entry and the search for a free
// slot share that single pass; the lock is written in the final cycle. Requests
// are taken one at a time: the next is accepted only after the previous result
// has been loaded into the output register.
//
// After reset the block runs a clearing pass that invalidates every entry;
// req_stall stays high until it ends. If the receiver stalls, the finished
// result sits in the output register and the next request is still accepted;
// only the following result waits until the slot frees.

module byte_range_lock_table
  import blt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int OBJECT_ID_BITS = OBJECT_ID_BITS_DEF,
  parameter int OWNER_ID_BITS = OWNER_ID_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  blt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output blt_rsp_t rsp
);

  localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EntryW = ENTRY_FIXED_BITS + OBJECT_ID_BITS + OWNER_ID_BITS;

  logic              slot_free;
  logic              res_load;
  blt_rsp_t          res_word;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [EntryW-1:0] mem_rdata;

  // Sequencer: reads one entry per cycle, tracks the first hit, conflicts,
  // the owner's entry and the first free slot, and writes back.
  blt_scan_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .OBJECT_ID_BITS(OBJECT_ID_BITS),
    .OWNER_ID_BITS(OWNER_ID_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .slot_free(slot_free),
    .res_load(res_load),
    .res_word(res_word),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Lock entries, valid bit included, live in one synchronous memory.
  blt_table_mem #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(EntryW),
    .ADDR_W(AddrW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // The output register decouples the result from the next request.
  blt_out_reg u_out (
    .clk(clk),
    .rst(rst),
    .load(res_load),
    .load_word(res_word),
    .slot_free(slot_free),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // A new result never overwrites one the receiver has not taken yet.
  assert property (@(posedge clk) disable iff (rst)
    res_load |-> !(rsp_valid && rsp_stall))
    else $error("result loaded over a stalled result word");

  // Once a request is accepted the block is busy scanning.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while a scan is under way");

  // Table writes always land inside the table.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (int'(mem_waddr) < TABLE_ENTRIES))
    else $error("table write address out of range");

  // A result is only produced while no request is being taken.
  assert property (@(posedge clk) disable iff (rst)
    res_load |-> req_stall)
    else $error("result loaded in the same cycle as a request");

endmodule

/* sim/tb_byte_range_lock_table.sv */
// Self-checking testbench for byte_range_lock_table: predicts every result word from its
// own copy of the lock table and checks the block's output field by field.
// Depends on blt_pkg and the byte_range_lock_table RTL only.

module tb_byte_range_lock_table;
  import blt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = TABLE_ENTRIES_DEF;

  // Kind codes that set the unlock bit. Kind three also carries the write bit, but the
  // block treats any kind with the unlock bit as a release.
  localparam logic [1:0] KIND_RELEASE     = 2'(1 << KIND_UNLOCK_BIT);
  localparam logic [1:0] KIND_RELEASE_ALT = KIND_RELEASE | KIND_WRITE;

  localparam logic [30:0] OFFSET_MAX = 31'h7fff_ffff;

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  blt_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  blt_rsp_t rsp;

  byte_range_lock_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow copy of the lock table. Entries are only looked at while their valid bit is
  // set, so the other fields need no reset.
  bit          held_valid  [ENTRIES];
  logic [31:0] held_object [ENTRIES];
  logic [30:0] held_start  [ENTRIES];
  logic [30:0] held_length [ENTRIES];
  bit          held_write  [ENTRIES];
  logic [15:0] held_owner  [ENTRIES];

  // Result words still owed by the block, oldest first.
  blt_rsp_t awaited_rsp[$];

  int error_count = 0;

  // When cleared, the sender or the receiver runs without any idle cycles.
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous watchdog: roughly 550 requests, each with a full table scan and random gaps, fit
  // into well under a millisecond, so this leaves several times the slowest correct run.
  initial begin
    #5ms;
    $display("byte_range_lock_table regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // A range end is one bit wider than an offset, so start plus length never wraps. A zero
  // length runs the range up to the top offset.
  function automatic logic [31:0] span_end(input logic [30:0] start, input logic [30:0] len);
    return (len == '0) ? RANGE_TOP : {1'b0, start} + {1'b0, len};
  endfunction

  function automatic bit spans_meet(input logic [30:0] s1, input logic [30:0] l1,
                                    input logic [30:0] s2, input logic [30:0] l2);
    logic [31:0] e1;
    logic [31:0] e2;
    e1 = span_end(s1, l1);
    e2 = span_end(s2, l2);
    return !(e1 <= {1'b0, s2} || e2 <= {1'b0, s1});
  endfunction

  // Applies one request to the shadow table and returns the result word it should give.
  function automatic blt_rsp_t apply_lock_request(input blt_req_t r);
    blt_rsp_t ans;
    bit       wants_write;
    ans            = '0;
    ans.status     = STATUS_DONE;
    ans.found_kind = FOUND_NONE;
    wants_write    = (r.lock_kind == KIND_WRITE);

    // A query reports the first overlapping entry on the object where either side writes.
    // The asking owner's own entries count too.
    if (r.operation == OP_QUERY) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (held_valid[i] && held_object[i] == r.object_id &&
            spans_meet(held_start[i], held_length[i], r.range_start, r.range_length) &&
            (held_write[i] || wants_write)) begin
          ans.found_kind   = held_write[i] ? FOUND_WRITE : FOUND_READ;
          ans.found_start  = held_start[i];
          ans.found_length = held_length[i];
          ans.found_owner  = held_owner[i];
          return ans;
        end
      end
      return ans;
    end

    // Release drops every entry of this owner on this object, even if there is none.
    if (r.lock_kind[KIND_UNLOCK_BIT]) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (held_valid[i] && held_object[i] == r.object_id && held_owner[i] == r.owner_id)
          held_valid[i] = 1'b0;
      end
      return ans;
    end

    for (int i = 0; i < ENTRIES; i++) begin
      if (held_valid[i] && held_object[i] == r.object_id && held_owner[i] != r.owner_id &&
          spans_meet(held_start[i], held_length[i], r.range_start, r.range_length) &&
          (held_write[i] || wants_write)) begin
        ans.status = STATUS_BLOCK;
        return ans;
      end
    end

    // An owner keeps at most one entry per object: its first one is rewritten in place.
    for (int i = 0; i < ENTRIES; i++) begin
      if (held_valid[i] && held_object[i] == r.object_id && held_owner[i] == r.owner_id) begin
        held_start[i]  = r.range_start;
        held_length[i] = r.range_length;
        held_write[i]  = wants_write;
        return ans;
      end
    end

    for (int i = 0; i < ENTRIES; i++) begin
      if (!held_valid[i]) begin
        held_valid[i]  = 1'b1;
        held_object[i] = r.object_id;
        held_start[i]  = r.range_start;
        held_length[i] = r.range_length;
        held_write[i]  = wants_write;
        held_owner[i]  = r.owner_id;
        return ans;
      end
    end

    ans.status = STATUS_FULL;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------------------

  // Sends one request word. Valid is left high after acceptance, so back-to-back words
  // never drop it within one time step; an idle gap or a drain lowers it instead.
  task automatic issue_request(input blt_req_t item);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    // The word moved at this edge: its result is owed from now on.
    awaited_rsp.push_back(apply_lock_request(item));
  endtask

  // Holds the sender off until every owed result word has come back.
  task automatic drain_answers();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic blt_req_t make_req(input logic op, input logic [31:0] obj,
                                        input logic [1:0] kind, input logic [30:0] start,
                                        input logic [30:0] len, input logic [15:0] owner);
    blt_req_t r;
    r.operation    = op;
    r.object_id    = obj;
    r.lock_kind    = kind;
    r.range_start  = start;
    r.range_length = len;
    r.owner_id     = owner;
    return r;
  endfunction

  // Random request, mostly on a few objects and owners so that locks collide, overlap and
  // get replaced; now and then with fully random ids and offsets so every bit toggles.
  function automatic blt_req_t random_request();
    blt_req_t r;
    int       pick;
    r.operation = ($urandom_range(0, 9) < 6) ? OP_SET : OP_QUERY;
    r.object_id = ($urandom_range(0, 6) == 0) ? $urandom : 32'($urandom_range(0, 5));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.owner_id = 16'hffff;
    else if (pick < 3)
      r.owner_id = 16'($urandom);
    else
      r.owner_id = 16'($urandom_range(0, 7));

    if (r.operation == OP_QUERY) begin
      r.lock_kind = 2'($urandom_range(0, 3));
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 8)
        r.lock_kind = KIND_READ;
      else if (pick < 15)
        r.lock_kind = KIND_WRITE;
      else if (pick < 19)
        r.lock_kind = KIND_RELEASE;
      else
        r.lock_kind = KIND_RELEASE_ALT;
    end

    case ($urandom_range(0, 9))
      0: begin
        r.range_start  = 31'($urandom);
        r.range_length = 31'($urandom);
      end
      1: begin
        r.range_start  = OFFSET_MAX - 31'($urandom_range(0, 300));
        r.range_length = 31'($urandom_range(0, 600));
      end
      default: begin
        r.range_start  = 31'($urandom_range(0, 400));
        r.range_length = ($urandom_range(0, 7) == 0) ? '0 : 31'($urandom_range(1, 120));
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------------------

  int hold_left = 0;

  // For every result word the receiver draws how many cycles it stalls afterwards. Values
  // are sampled right at the edge, before any register of this step updates.
  always @(posedge clk) begin
    blt_rsp_t want;
    if (rst) begin
      hold_left = 0;
    end else if (rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("result word with no request pending: %h", rsp));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.found_kind !== want.found_kind)
          report_mismatch($sformatf("found_kind got %0d want %0d",
                                    rsp.found_kind, want.found_kind));
        if (rsp.found_start !== want.found_start)
          report_mismatch($sformatf("found_start got %h want %h",
                                    rsp.found_start, want.found_start));
        if (rsp.found_length !== want.found_length)
          report_mismatch($sformatf("found_length got %h want %h",
                                    rsp.found_length, want.found_length));
        if (rsp.found_owner !== want.found_owner)
          report_mismatch($sformatf("found_owner got %h want %h",
                                    rsp.found_owner, want.found_owner));
      end
      hold_left = receiver_gaps ? $urandom_range(0, 10) : 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    rsp_stall <= (hold_left > 0);
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Field extremes, both operations, every lock kind and the corner cases of the rules:
  // empty table, own entries seen by a query, kind three in both operations, zero length,
  // ranges that only touch, in-place replacement and release of nothing.
  task automatic test_directed_corners();
    // Query on the empty table finds nothing.
    issue_request(make_req(OP_QUERY, 32'h0, KIND_READ, '0, '0, 16'h0));
    // Write lock at the very top: its end needs the extra bit.
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_WRITE, OFFSET_MAX, OFFSET_MAX,
                           16'hffff));
    // The owner's own write lock is reported to its own query.
    issue_request(make_req(OP_QUERY, 32'hffff_ffff, KIND_READ, OFFSET_MAX, 31'd1, 16'hffff));
    issue_request(make_req(OP_QUERY, 32'h0, KIND_WRITE, OFFSET_MAX, 31'd1, 16'hffff));
    // A read lock that ends exactly where the write lock starts does not meet it.
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_READ, '0, OFFSET_MAX, 16'h0001));
    // One byte of overlap with the other owner's write lock blocks.
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_READ, OFFSET_MAX - 31'd1, 31'd2,
                           16'h0002));
    // Kind three in a query is a read request: only the write entry is reported.
    issue_request(make_req(OP_QUERY, 32'hffff_ffff, KIND_RELEASE_ALT, 31'h7fff_fff0,
                           31'h100, 16'h0003));
    // A write query reports the first overlapping entry, here a read lock.
    issue_request(make_req(OP_QUERY, 32'hffff_ffff, KIND_WRITE, '0, '0, 16'h0003));
    // Existing lock of owner one is replaced by a zero-length write lock.
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_WRITE, 31'd5, '0, 16'h0001));
    issue_request(make_req(OP_QUERY, 32'hffff_ffff, KIND_READ, '0, 31'd6, 16'h0009));
    // Kind three in a set request releases.
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_RELEASE_ALT, '0, '0, 16'h0001));
    issue_request(make_req(OP_QUERY, 32'hffff_ffff, KIND_READ, '0, '0, 16'h0009));
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_RELEASE, OFFSET_MAX, OFFSET_MAX,
                           16'hffff));
    // Releasing with nothing held still completes.
    issue_request(make_req(OP_SET, 32'hffff_ffff, KIND_RELEASE, '0, '0, 16'h0007));
    issue_request(make_req(OP_QUERY, 32'hffff_ffff, KIND_WRITE, OFFSET_MAX, OFFSET_MAX,
                           16'h0007));
    // Shared read locks coexist; a write against another owner's read blocks.
    issue_request(make_req(OP_SET, 32'h0, KIND_READ, '0, 31'd1, 16'h0000));
    issue_request(make_req(OP_SET, 32'h0, KIND_READ, '0, 31'd1, 16'h0003));
    issue_request(make_req(OP_SET, 32'h0, KIND_WRITE, '0, 31'd1, 16'h0003));
    issue_request(make_req(OP_SET, 32'h0, KIND_WRITE, '0, 31'd1, 16'h0000));
    issue_request(make_req(OP_SET, 32'h0, KIND_RELEASE, '0, '0, 16'h0003));
    // With the other reader gone the upgrade to a write lock goes through.
    issue_request(make_req(OP_SET, 32'h0, KIND_WRITE, '0, 31'd1, 16'h0000));
    issue_request(make_req(OP_QUERY, 32'h0, KIND_READ, '0, '0, 16'h0000));
    issue_request(make_req(OP_SET, 32'h0, KIND_RELEASE, '0, '0, 16'h0000));
    drain_answers();
  endtask

  // Fills every slot with read locks of distinct owners until the table reports full,
  // frees a few slots, refills them past capacity again, then releases everything.
  task automatic test_table_capacity();
    logic [31:0] filled_obj[70];
    logic [31:0] refill_obj[12];
    for (int i = 0; i < 70; i++) begin
      filled_obj[i] = 32'($urandom_range(0, 3));
      issue_request(make_req(OP_SET, filled_obj[i], KIND_READ, 31'($urandom_range(0, 1000)),
                             31'($urandom_range(0, 100)), 16'h4000 + 16'(i)));
    end
    // Queries and a write attempt against a full table.
    for (int i = 0; i < 4; i++)
      issue_request(make_req(OP_QUERY, 32'(i), KIND_WRITE, '0, '0, 16'h0abc));
    issue_request(make_req(OP_SET, filled_obj[3], KIND_WRITE, '0, '0, 16'h4003));
    for (int i = 0; i < 10; i++)
      issue_request(make_req(OP_SET, filled_obj[i], KIND_RELEASE, '0, '0, 16'h4000 + 16'(i)));
    for (int i = 0; i < 12; i++) begin
      refill_obj[i] = 32'($urandom_range(0, 3));
      issue_request(make_req(OP_SET, refill_obj[i], KIND_READ, 31'($urandom_range(0, 1000)),
                             31'($urandom_range(0, 100)), 16'h5000 + 16'(i)));
    end
    for (int i = 10; i < 70; i++)
      issue_request(make_req(OP_SET, filled_obj[i], KIND_RELEASE, '0, '0, 16'h4000 + 16'(i)));
    for (int i = 0; i < 12; i++)
      issue_request(make_req(OP_SET, refill_obj[i], KIND_RELEASE_ALT, '0, '0,
                             16'h5000 + 16'(i)));
    drain_answers();
  endtask

  // Random traffic in chunks; each chunk picks whether sender and receiver idle, so there
  // are stretches of back-to-back words on either side. Halfway the sender drains once.
  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 18; chunk++) begin
      sender_gaps   = ($urandom_range(0, 3) != 0);
      receiver_gaps = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 20; n++)
        issue_request(random_request());
      if (chunk == 8)
        drain_answers();
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    drain_answers();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // The block clears its table after reset and stalls requests meanwhile; the first
    // request simply waits for that handshake.
    test_directed_corners();
    test_table_capacity();
    test_random_traffic();
    // Everything came back; give the block one more full pass for stray words.
    repeat (ENTRIES + 10) @(posedge clk);
    if (error_count == 0)
      $display("byte_range_lock_table regression: pass");
    else
      $display("byte_range_lock_table regression: fail");
    $finish;
  end

endmodule
